>>> hdl/staged_command_ring_core_macros.svh
// Assertion macros shared by the staged command ring RTL.
// Included by the top level; depends on nothing else.
`ifndef STAGED_COMMAND_RING_CORE_MACROS_SVH
`define STAGED_COMMAND_RING_CORE_MACROS_SVH

// Asserts an implication on every clock edge outside reset.
`define SCR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts an implication in the next cycle outside reset.
`define SCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/scr_pkg.sv
// Package for the staged command ring: operation and status codes, shared types.
// No dependencies.
`default_nettype none
package scr_pkg;
  localparam int unsigned RingDepthDefault = 1024;
  localparam logic [10:0] CapacityReset = 11'd1024;
  localparam logic [63:0] FirstSeqReset = 64'd1;

  typedef enum logic [3:0] {
    OP_PUBLISH     = 4'd0,
    OP_REPLAY      = 4'd1,
    OP_RESTORE     = 4'd2,
    OP_COPY        = 4'd3,
    OP_DURABLE     = 4'd4,
    OP_FAIL        = 4'd5,
    OP_READ_RISK   = 4'd6,
    OP_RISK        = 4'd7,
    OP_READ_RES    = 4'd8,
    OP_RES_CONSUME = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_PERSIST      = 3'd1,
    ST_EXHAUSTED    = 3'd2,
    ST_BAD_SEQ      = 3'd3,
    ST_FULL         = 3'd4,
    ST_EMPTY        = 3'd5,
    ST_BAD_COUNT    = 3'd6,
    ST_BAD_DECISION = 3'd7
  } status_e;

  localparam logic [3:0] OpPublish = 4'd0;
  localparam logic [3:0] OpReplay = 4'd1;
  localparam logic [3:0] OpRestore = 4'd2;
  localparam logic [3:0] OpCopy = 4'd3;
  localparam logic [3:0] OpDurable = 4'd4;
  localparam logic [3:0] OpFail = 4'd5;
  localparam logic [3:0] OpReadRisk = 4'd6;
  localparam logic [3:0] OpRisk = 4'd7;
  localparam logic [3:0] OpReadRes = 4'd8;
  localparam logic [3:0] OpResConsume = 4'd9;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StPersist = 3'd1;
  localparam logic [2:0] StExhausted = 3'd2;
  localparam logic [2:0] StBadSeq = 3'd3;
  localparam logic [2:0] StFull = 3'd4;
  localparam logic [2:0] StEmpty = 3'd5;
  localparam logic [2:0] StBadCount = 3'd6;
  localparam logic [2:0] StBadDecision = 3'd7;

  // One request as it travels from the front part to the back part.
  typedef struct packed {
    logic [3:0]  operation;
    logic        operation_ext;
    logic [63:0] command_payload;
    logic [63:0] given_sequence;
    logic [31:0] offset_or_count;
    logic [1:0]  check_decision;
    logic [63:0] check_data;
  } req_t;
endpackage
`default_nettype wire

>>> hdl/scr_ram.sv
// Generic RAM with one write port, one read port and registered read data.
// No dependencies.
`default_nettype none
module scr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hdl/scr_front.sv
// Front part: accepts requests into a two-entry queue.
// Depends on scr_pkg.
`default_nettype none
module scr_front import scr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_req_i,
  output logic      q_valid_o,
  input  wire logic q_pop_i,
  output req_t      q_req_o
);
  req_t req_q [2];
  logic [1:0] cnt_q;
  logic rd_q, wr_q;
  logic push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o = req_q[rd_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      req_q[wr_q] <= in_req_i;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (q_pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule
`default_nettype wire

>>> hdl/scr_back.sv
// Back part: cursor state, slot memories and result register.
// Depends on scr_pkg and scr_ram.
`default_nettype none
module scr_back import scr_pkg::*; #(
  parameter int unsigned RingDepth = RingDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  output logic             q_pop_o,
  input  wire req_t        q_req_i,
  input  wire logic        reinit_i,
  input  wire logic [10:0] capacity_i,
  input  wire logic [63:0] first_seq_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [63:0]      result_sequence_o,
  output logic [63:0]      result_position_o,
  output logic [63:0]      out_payload_o,
  output logic [1:0]       out_risk_decision_o,
  output logic [63:0]      out_risk_data_o,
  output logic [1:0]       out_reserve_decision_o,
  output logic [63:0]      out_reserve_data_o
);
  localparam int unsigned IW = $clog2(RingDepth);
  localparam int unsigned SlotW = 64 + 64 + 2 + 64 + 2 + 64;
  localparam logic [16:0] DepthW = 17'(RingDepth);

  typedef enum logic [1:0] {
    S_DECIDE = 2'b01,
    S_FINISH = 2'b10
  } state_e;

  state_e state_q, state_d;
  req_t req_q;
  logic [63:0] cnt_q [5];
  logic [IW-1:0] idx_q [5];
  logic [63:0] next_seq_q;
  logic seq_done_q, failed_q;
  logic [IW-1:0] last_idx;
  logic [IW:0] cap_full;

  // Slot memory port.
  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr, raddr_q;
  logic [SlotW-1:0] ram_wdata, ram_rdata;

  // Decide-cycle results.
  logic [2:0] st_d, st_q;
  logic [63:0] pos_d, pos_q, seq_r_q;
  logic wrr_q, wrs_q;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic [2:0] o_st_q;
  logic [63:0] o_seq_q, o_pos_q, o_pay_q, o_rkd_q, o_rsd_q;
  logic [1:0] o_rk_q, o_rs_q;

  // Effective capacity: zero acts as one, large values act as the depth.
  always_comb begin
    logic [16:0] c;
    c = {6'd0, capacity_i};
    if (c == 17'd0) c = 17'd1;
    if (c > DepthW) c = DepthW;
    cap_full = (IW+1)'(c);
    last_idx = IW'(c - 17'd1);
  end

  function automatic logic [IW-1:0] wrap1(input logic [IW-1:0] i, input logic [IW-1:0] lastv);
    logic [IW-1:0] r;
    r = (i == lastv) ? '0 : i + IW'(1);
    return r;
  endfunction

  // Durable index plus an offset or count. A valid amount never exceeds the
  // capacity, so one compare and subtract wraps the sum.
  logic [IW:0] amt, amt_rd;
  logic [IW+1:0] sum_rd, sum_full;
  logic [IW-1:0] wrap_idx, dur_full;
  always_comb begin
    amt = q_req_i.offset_or_count[IW:0];
    amt_rd = (q_req_i.operation == OpDurable) ? amt - (IW+1)'(1) : amt;
    sum_rd = {2'b0, idx_q[1]} + {1'b0, amt_rd};
    if (sum_rd >= {1'b0, cap_full}) sum_rd = sum_rd - {1'b0, cap_full};
    sum_full = {2'b0, idx_q[1]} + {1'b0, amt};
    if (sum_full >= {1'b0, cap_full}) sum_full = sum_full - {1'b0, cap_full};
    wrap_idx = sum_rd[IW-1:0];
    dur_full = sum_full[IW-1:0];
  end

  // Taken in decide without reinit, when the result register is free or drains this cycle.
  logic go;
  assign go = q_valid_i && state_q == S_DECIDE && !reinit_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = go;

  // Decode and check one request against the cursors.
  logic [63:0] copy_pos, head_room, dur_room;
  logic [IW-1:0] rd_idx;
  logic wr_head, wr_risk, wr_res, adv_dur, adv_tail;

  always_comb begin
    st_d = StOk;
    pos_d = '0;
    rd_idx = idx_q[0];
    wr_head = 1'b0;
    wr_risk = 1'b0;
    wr_res = 1'b0;
    adv_dur = 1'b0;
    adv_tail = 1'b0;
    copy_pos = cnt_q[1] + {32'd0, q_req_i.offset_or_count};
    head_room = cnt_q[0] - cnt_q[4];
    dur_room = cnt_q[0] - cnt_q[1];
    unique case (q_req_i.operation)
      OpPublish: begin
        if (failed_q) st_d = StPersist;
        else if (seq_done_q) st_d = StExhausted;
        else if (head_room >= 64'(cap_full)) st_d = StFull;
        else begin wr_head = 1'b1; pos_d = cnt_q[0] + 64'd1; end
      end
      OpReplay: begin
        if (failed_q) st_d = StPersist;
        else if (q_req_i.given_sequence == 64'd0) st_d = StBadSeq;
        else if (head_room >= 64'(cap_full)) st_d = StFull;
        else begin wr_head = 1'b1; pos_d = cnt_q[0] + 64'd1; end
      end
      OpRestore: begin
        if (q_req_i.given_sequence == 64'd0) st_d = StBadSeq;
      end
      OpCopy: begin
        if (failed_q) st_d = StPersist;
        else if (copy_pos < cnt_q[1] || copy_pos >= cnt_q[0]) st_d = StEmpty;
        else begin rd_idx = wrap_idx; pos_d = copy_pos; end
      end
      OpDurable: begin
        if (failed_q) st_d = StPersist;
        else if (q_req_i.offset_or_count == 32'd0
                 || {32'd0, q_req_i.offset_or_count} > dur_room) st_d = StBadCount;
        else begin
          adv_dur = 1'b1;
          rd_idx = wrap_idx;
          pos_d = copy_pos;
        end
      end
      OpReadRisk: begin
        if (cnt_q[2] == cnt_q[1]) st_d = StEmpty;
        else begin rd_idx = idx_q[2]; pos_d = cnt_q[2]; end
      end
      OpReadRes: begin
        if (cnt_q[3] == cnt_q[2]) st_d = StEmpty;
        else begin rd_idx = idx_q[3]; pos_d = cnt_q[3]; end
      end
      OpRisk: begin
        if (q_req_i.check_decision == 2'd0) st_d = StBadDecision;
        else if (cnt_q[2] == cnt_q[1]) st_d = StEmpty;
        else begin wr_risk = 1'b1; rd_idx = idx_q[2]; pos_d = cnt_q[2] + 64'd1; end
      end
      OpResConsume: begin
        if (q_req_i.operation_ext) begin
          if (cnt_q[4] == cnt_q[3]) st_d = StEmpty;
          else begin adv_tail = 1'b1; rd_idx = idx_q[4]; pos_d = cnt_q[4] + 64'd1; end
        end else if (q_req_i.check_decision == 2'd0) st_d = StBadDecision;
        else if (cnt_q[3] == cnt_q[2]) st_d = StEmpty;
        else begin wr_res = 1'b1; rd_idx = idx_q[3]; pos_d = cnt_q[3] + 64'd1; end
      end
      default: ;
    endcase
  end

  // Slot layout: sequence, payload, risk decision, risk data, reserve decision, reserve data.
  assign ram_raddr = rd_idx;
  scr_ram #(.Width(SlotW), .Depth(RingDepth)) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Slot write: head commands at decide, check results merged at finish.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx_q[0];
    ram_wdata = {(q_req_i.operation == OpPublish) ? next_seq_q : q_req_i.given_sequence,
                 q_req_i.command_payload, 2'd0, 64'd0, 2'd0, 64'd0};
    if (go && wr_head) begin
      ram_we = 1'b1;
    end else if (state_q == S_FINISH && (wrr_q || wrs_q)) begin
      ram_we = 1'b1;
      ram_waddr = raddr_q;
      ram_wdata = ram_rdata;
      if (wrr_q) ram_wdata[131:66] = {req_q.check_decision, req_q.check_data};
      else ram_wdata[65:0] = {req_q.check_decision, req_q.check_data};
    end
  end

  // Two-state sequencer: decide, then finish with the slot read data.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_DECIDE: if (go) state_d = S_FINISH;
      S_FINISH: state_d = S_DECIDE;
      default: state_d = S_DECIDE;
    endcase
  end

  // The result register fills at finish and holds while stalled.
  assign out_valid_d = (out_valid_q && out_stall_i) || (state_q == S_FINISH);

  // Cursor and flag updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_DECIDE;
      for (int j = 0; j < 5; j++) begin cnt_q[j] <= '0; idx_q[j] <= '0; end
      next_seq_q <= FirstSeqReset;
      seq_done_q <= 1'b0;
      failed_q <= 1'b0;
      out_valid_q <= 1'b0;
      wrr_q <= 1'b0;
      wrs_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (reinit_i) begin
        for (int j = 0; j < 5; j++) begin cnt_q[j] <= '0; idx_q[j] <= '0; end
        next_seq_q <= (first_seq_i == 64'd0) ? 64'd1 : first_seq_i;
        seq_done_q <= 1'b0;
        failed_q <= 1'b0;
      end else if (go) begin
        wrr_q <= wr_risk;
        wrs_q <= wr_res;
        if (wr_head) begin
          cnt_q[0] <= pos_d;
          idx_q[0] <= wrap1(idx_q[0], last_idx);
          if (q_req_i.operation == OpPublish) begin
            if (next_seq_q == '1) seq_done_q <= 1'b1;
            else next_seq_q <= next_seq_q + 64'd1;
          end
        end
        if (q_req_i.operation == OpRestore && st_d == StOk) begin
          next_seq_q <= q_req_i.given_sequence;
          seq_done_q <= 1'b0;
        end
        if (q_req_i.operation == OpFail) failed_q <= 1'b1;
        if (adv_dur) begin
          cnt_q[1] <= pos_d;
          idx_q[1] <= dur_full;
        end
        if (wr_risk) begin cnt_q[2] <= pos_d; idx_q[2] <= wrap1(idx_q[2], last_idx); end
        if (wr_res) begin cnt_q[3] <= pos_d; idx_q[3] <= wrap1(idx_q[3], last_idx); end
        if (adv_tail) begin cnt_q[4] <= pos_d; idx_q[4] <= wrap1(idx_q[4], last_idx); end
      end else if (state_q == S_FINISH) begin
        wrr_q <= 1'b0;
        wrs_q <= 1'b0;
      end
    end
  end

  // Request details kept for the finish cycle.
  always_ff @(posedge clk_i) begin
    if (go) begin
      req_q <= q_req_i;
      st_q <= st_d;
      pos_q <= pos_d;
      raddr_q <= rd_idx;
      seq_r_q <= (q_req_i.operation == OpPublish) ? next_seq_q : q_req_i.given_sequence;
    end
  end

  // Result fields from the decision and the slot read.
  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH) begin
      o_st_q <= st_q;
      o_seq_q <= '0; o_pos_q <= '0; o_pay_q <= '0;
      o_rk_q <= '0; o_rkd_q <= '0; o_rs_q <= '0; o_rsd_q <= '0;
      if (st_q == StOk) begin
        case (req_q.operation)
          OpPublish, OpReplay: begin o_seq_q <= seq_r_q; o_pos_q <= pos_q; end
          OpCopy, OpReadRisk: begin
            o_seq_q <= ram_rdata[259:196]; o_pos_q <= pos_q; o_pay_q <= ram_rdata[195:132];
          end
          OpDurable, OpRisk: begin o_seq_q <= ram_rdata[259:196]; o_pos_q <= pos_q; end
          OpReadRes: begin
            o_seq_q <= ram_rdata[259:196]; o_pos_q <= pos_q; o_pay_q <= ram_rdata[195:132];
            o_rk_q <= ram_rdata[131:130]; o_rkd_q <= ram_rdata[129:66];
          end
          OpResConsume: begin
            o_seq_q <= ram_rdata[259:196]; o_pos_q <= pos_q;
            if (req_q.operation_ext) begin
              o_pay_q <= ram_rdata[195:132];
              o_rk_q <= ram_rdata[131:130]; o_rkd_q <= ram_rdata[129:66];
              o_rs_q <= ram_rdata[65:64]; o_rsd_q <= ram_rdata[63:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = o_st_q;
  assign result_sequence_o = o_seq_q;
  assign result_position_o = o_pos_q;
  assign out_payload_o = o_pay_q;
  assign out_risk_decision_o = o_rk_q;
  assign out_risk_data_o = o_rkd_q;
  assign out_reserve_decision_o = o_rs_q;
  assign out_reserve_data_o = o_rsd_q;
endmodule
`default_nettype wire

>>> hdl/staged_command_ring_core.sv
// Top level of the staged command ring: register port, front queue, back part.
// Depends on scr_pkg, scr_front, scr_back and the macros header.
//
//  channel  | handshake                 | payload
//  in       | in_valid_i / in_stall_o   | operation .. check_data
//  out      | out_valid_o / out_stall_i | status .. out_reserve_data
//  config   | psel/penable/pwrite       | paddr, pwdata
//
// A request passes through the back part's decide state (decide and cursor update),
// then its finish state (slot read and result); no new request is taken in finish.
// The result is registered at the end of the finish state.
// Reset clears cursors and flags; slot memory is not cleared.
// The input stalls while two requests wait in the front queue.
// A stalled output holds the back part in its decide cycle.
`default_nettype none
`include "staged_command_ring_core_macros.svh"
module staged_command_ring_core import scr_pkg::*; #(
  parameter int unsigned RingDepth = RingDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  operation_i,
  input  wire logic        operation_ext_i,
  input  wire logic [63:0] command_payload_i,
  input  wire logic [63:0] given_sequence_i,
  input  wire logic [31:0] offset_or_count_i,
  input  wire logic [1:0]  check_decision_i,
  input  wire logic [63:0] check_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [63:0]      result_sequence_o,
  output logic [63:0]      result_position_o,
  output logic [63:0]      out_payload_o,
  output logic [1:0]       out_risk_decision_o,
  output logic [63:0]      out_risk_data_o,
  output logic [1:0]       out_reserve_decision_o,
  output logic [63:0]      out_reserve_data_o
);
  localparam logic [3:0] AddrCapacity = 4'd0;
  localparam logic [3:0] AddrFirstSeq = 4'd8;

  logic [10:0] cap_q;
  logic [63:0] first_q, first_seq_in;
  logic wr, reinit;
  req_t in_req, q_req;
  logic q_valid, q_pop;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign reinit = wr && (paddr == AddrCapacity || paddr == AddrFirstSeq);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
      first_q <= FirstSeqReset;
    end else if (wr) begin
      if (paddr == AddrCapacity) cap_q <= pwdata[10:0];
      if (paddr == AddrFirstSeq) first_q <= pwdata;
    end
  end
  assign prdata = (paddr == AddrCapacity) ? {53'd0, cap_q} :
                  (paddr == AddrFirstSeq) ? first_q : 64'd0;

  // The back part reloads its sequence from the value being written.
  assign first_seq_in = (wr && paddr == AddrFirstSeq) ? pwdata : first_q;

  assign in_req = '{operation: operation_i, operation_ext: operation_ext_i,
                    command_payload: command_payload_i, given_sequence: given_sequence_i,
                    offset_or_count: offset_or_count_i, check_decision: check_decision_i,
                    check_data: check_data_i};

  scr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i(in_req),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  scr_back #(.RingDepth(RingDepth)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .reinit_i(reinit), .capacity_i(cap_q), .first_seq_i(first_seq_in),
    .out_valid_o, .out_stall_i, .status_o, .result_sequence_o, .result_position_o,
    .out_payload_o, .out_risk_decision_o, .out_risk_data_o,
    .out_reserve_decision_o, .out_reserve_data_o
  );

  // A held result stays until taken.
  `SCR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // Error results carry no sequence.
  `SCR_ASSERT_IMPL(a_err_zero, out_valid_o && status_o != StOk, result_sequence_o == 64'd0)
endmodule
`default_nettype wire
